FILE: rtl/kpe_pkg.sv
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared types, constants and the hex digit table of the key encoder.
// ----------------------------------------------------------------------------
package kpe_pkg;

  localparam logic [31:0] FnvBasis   = 32'd2166136261;
  localparam logic [31:0] FnvPrime   = 32'd16777619;
  localparam logic [7:0]  LimitReset = 8'd96;
  localparam logic [7:0]  Blocked    = 8'd255;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);

  localparam logic [7:0] ChPct  = 8'h25;
  localparam logic [7:0] ChDash = 8'h2d;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_ESC
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAIN,
    ST_PCT,
    ST_HI,
    ST_LO,
    ST_DASH,
    ST_HASH
  } back_state_e;

  // one unit of work handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  key_byte;
    logic        is_last;
    logic [31:0] hash;
  } entry_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    case (nib)
      4'h0: ch = 8'h30;
      4'h1: ch = 8'h31;
      4'h2: ch = 8'h32;
      4'h3: ch = 8'h33;
      4'h4: ch = 8'h34;
      4'h5: ch = 8'h35;
      4'h6: ch = 8'h36;
      4'h7: ch = 8'h37;
      4'h8: ch = 8'h38;
      4'h9: ch = 8'h39;
      4'ha: ch = 8'h61;
      4'hb: ch = 8'h62;
      4'hc: ch = 8'h63;
      4'hd: ch = 8'h64;
      4'he: ch = 8'h65;
      default: ch = 8'h66;
    endcase
    return ch;
  endfunction

endpackage

FILE: rtl/key_percent_encode_with_hash_core.sv
// ----------------------------------------------------------------------------
// key_percent_encode_with_hash_core
// Streaming percent encoder for keys with a '-' and FNV-1a hash suffix.
// ----------------------------------------------------------------------------
// A key enters one byte per beat; a new byte is taken every cycle while the
// four-entry work queue has room. Each byte leaves as 1 character (unreserved)
// or 3 characters (escape unit), or none once the prefix limit is reached,
// and the last beat adds 9 more ('-' and eight hash digits), so an item
// yields 0 to 12 characters: the output register delivers one character per
// cycle while results are popped or absent, which sets the sustained rate.
// Results pass the work queue, the back's state and the output register on
// the way to the result ports. No clearing pass follows reset.
module key_percent_encode_with_hash_core import kpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] key_byte_i,
  input  logic       has_byte_i,
  input  logic       is_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wr_entry, q_rd_entry;

  kpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .key_byte_i  (key_byte_i),
    .has_byte_i  (has_byte_i),
    .is_last_i   (is_last_i),
    .full_o      (full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_wr_entry)
  );

  kpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  kpe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_entry_i  (q_rd_entry),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o)
  );

endmodule

FILE: rtl/kpe_front.sv
// ----------------------------------------------------------------------------
// kpe_front
// Accepts key bytes, classifies them, checks the prefix limit and runs the
// FNV-1a hash; pushes one entry per item that produces characters.
// ----------------------------------------------------------------------------
module kpe_front import kpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] key_byte_i,
  input  logic       has_byte_i,
  input  logic       is_last_i,
  output logic       full_o,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  output logic       cfg_ready_o,
  input  logic       q_full_i,
  output logic       q_push_o,
  output entry_t     q_entry_o
);

  logic [31:0] hash_q, hash_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  limit_q;

  logic        accept;
  logic        plain;
  logic [8:0]  unit_len;
  logic [8:0]  count_sum;
  logic        fits;
  logic [31:0] hash_mix;
  logic [31:0] hash_new;
  kind_e       kind;

  assign full_o      = q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !q_full_i;

  always_comb begin
    plain = ((key_byte_i >= 8'h41) && (key_byte_i <= 8'h5a)) ||
            ((key_byte_i >= 8'h61) && (key_byte_i <= 8'h7a)) ||
            ((key_byte_i >= 8'h30) && (key_byte_i <= 8'h39)) ||
            (key_byte_i == 8'h2e) || (key_byte_i == 8'h5f) || (key_byte_i == 8'h2d);
    unit_len  = plain ? 9'd1 : 9'd3;
    count_sum = {1'b0, count_q} + unit_len;
    fits      = count_sum <= {1'b0, limit_q};
    if (has_byte_i && fits) begin
      kind = plain ? KIND_PLAIN : KIND_ESC;
    end else begin
      kind = KIND_NONE;
    end
    hash_mix = hash_q ^ {24'd0, key_byte_i};
    hash_new = has_byte_i ? (hash_mix * FnvPrime) : hash_q;
  end

  always_comb begin
    hash_d  = hash_q;
    count_d = count_q;
    if (accept) begin
      if (is_last_i) begin
        hash_d  = FnvBasis;
        count_d = '0;
      end else if (has_byte_i) begin
        hash_d  = hash_new;
        count_d = fits ? count_sum[7:0] : Blocked;
      end
    end
  end

  assign q_push_o           = accept && ((kind != KIND_NONE) || is_last_i);
  assign q_entry_o.kind     = kind;
  assign q_entry_o.key_byte = key_byte_i;
  assign q_entry_o.is_last  = is_last_i;
  assign q_entry_o.hash     = hash_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= FnvBasis;
      count_q <= '0;
      limit_q <= LimitReset;
    end else begin
      hash_q  <= hash_d;
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

endmodule

FILE: rtl/kpe_queue.sv
// ----------------------------------------------------------------------------
// kpe_queue
// Short flop queue of work entries between the front and the back.
// ----------------------------------------------------------------------------
module kpe_queue import kpe_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QDepth[QPtrW:0]);
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: rtl/kpe_back.sv
// ----------------------------------------------------------------------------
// kpe_back
// Expands each entry into output characters, one per cycle while the result is
// popped or absent, and holds the oldest character in the output register.
// ----------------------------------------------------------------------------
module kpe_back import kpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  entry_t     q_entry_i,
  output logic       q_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  back_state_e state_q, state_d;
  entry_t      cur_q;
  logic [31:0] hash_sh_q;
  logic [2:0]  nib_cnt_q;
  logic        out_valid_q;
  logic [7:0]  out_char_q;
  logic        out_last_q;

  logic        adv;
  logic        emit;
  logic [7:0]  ch;
  logic        lst;
  logic        fin;
  logic        load;
  back_state_e first_state;

  assign adv = !out_valid_q || pop;

  // character of the current step and whether the entry ends with it
  always_comb begin
    emit = 1'b1;
    ch   = '0;
    lst  = 1'b0;
    fin  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        emit = 1'b0;
      end
      ST_PLAIN: begin
        ch  = cur_q.key_byte;
        fin = !cur_q.is_last;
      end
      ST_PCT: begin
        ch = ChPct;
      end
      ST_HI: begin
        ch = hex_char(cur_q.key_byte[7:4]);
      end
      ST_LO: begin
        ch  = hex_char(cur_q.key_byte[3:0]);
        fin = !cur_q.is_last;
      end
      ST_DASH: begin
        ch = ChDash;
      end
      ST_HASH: begin
        ch  = hex_char(hash_sh_q[31:28]);
        lst = (nib_cnt_q == '0);
        fin = lst;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (q_entry_i.kind)
      KIND_PLAIN: first_state = ST_PLAIN;
      KIND_ESC:   first_state = ST_PCT;
      default:    first_state = ST_DASH;
    endcase
  end

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    if (adv) begin
      if ((state_q == ST_IDLE) || fin) begin
        if (!q_empty_i) begin
          load    = 1'b1;
          state_d = first_state;
        end else begin
          state_d = ST_IDLE;
        end
      end else begin
        unique case (state_q)
          ST_PLAIN: state_d = ST_DASH;
          ST_PCT:   state_d = ST_HI;
          ST_HI:    state_d = ST_LO;
          ST_LO:    state_d = ST_DASH;
          ST_DASH:  state_d = ST_HASH;
          ST_HASH:  state_d = ST_HASH;
          default:  state_d = ST_IDLE;
        endcase
      end
    end
  end

  assign q_pop_o    = load;
  assign empty      = !out_valid_q;
  assign out_char_o = out_char_q;
  assign out_last_o = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adv) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q     <= q_entry_i;
      hash_sh_q <= q_entry_i.hash;
      nib_cnt_q <= 3'd7;
    end else if (adv && (state_q == ST_HASH)) begin
      hash_sh_q <= {hash_sh_q[27:0], 4'h0};
      nib_cnt_q <= nib_cnt_q - 1'b1;
    end
    if (adv) begin
      out_char_q <= ch;
      out_last_q <= lst;
    end
  end

endmodule

FILE: rtl/kpe_checker.sv
// ----------------------------------------------------------------------------
// kpe_checker
// Port-level checks on the key encoder, bound to the top level.
// ----------------------------------------------------------------------------
module kpe_checker import kpe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char_o,
  input logic       out_last_o
);

  // the final character of a name is always a lowercase hex digit
  a_last_is_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_last_o) |->
      (((out_char_o >= 8'h30) && (out_char_o <= 8'h39)) ||
       ((out_char_o >= 8'h61) && (out_char_o <= 8'h66))))
    else $error("final beat is not a hex digit");

  // a waiting beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_char_o) && $stable(out_last_o)))
    else $error("result beat changed while stalled");

  // the queue only fills up right after an input beat
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without an input beat");

  // a waiting result beat is always fully defined
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !$isunknown({out_char_o, out_last_o}))
    else $error("result beat carries unknown bits");

endmodule

bind key_percent_encode_with_hash_core kpe_checker u_kpe_checker (.*);
